@@ rtl/core/bba_pkg.sv @@
// Shared constants, codes and helper functions of the bitmap block allocator.
`default_nettype none

package bba_pkg;

   localparam int MAP_WORDS_DEF = 1024;

   localparam int OP_W   = 3;
   localparam int IDX_W  = 10;
   localparam int DATA_W = 32;
   localparam int BLK_W  = 15;
   localparam int WIU_W  = 11;

   localparam logic [WIU_W-1:0]  WIU_RESET = 11'd1024;
   localparam logic [DATA_W-1:0] ALL_USED  = 32'hFFFF_FFFF;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE_WORD  = 3'd0,
      OP_ALLOCATE    = 3'd1,
      OP_SET_COUNT   = 3'd2,
      OP_READ_WORD   = 3'd3,
      OP_CLEAR_DIRTY = 3'd4
   } op_type;

   // Position of the lowest clear bit; meaningful only when one exists.
   function automatic logic [4:0] first_clear(input logic [DATA_W-1:0] word);
      logic [4:0] pos;
      pos = '0;
      for (int i = DATA_W - 1; i >= 0; i--) begin
         if (!word[i]) begin
            pos = 5'(i);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/bba_channels.sv @@
// Valid/ready channel interfaces for request, response and register write words.
`default_nettype none

interface bba_req_if;
   logic                       valid;
   logic                       ready;
   logic [bba_pkg::OP_W-1:0]   operation;
   logic [bba_pkg::IDX_W-1:0]  word_index;
   logic [bba_pkg::DATA_W-1:0] word_data;

   modport source (output valid, operation, word_index, word_data, input ready);
   modport sink   (input valid, operation, word_index, word_data, output ready);
endinterface

interface bba_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       found;
   logic [bba_pkg::BLK_W-1:0]  block_number;
   logic [bba_pkg::DATA_W-1:0] read_data;
   logic [bba_pkg::DATA_W-1:0] free_count;
   logic                       dirty;

   modport source (output valid, found, block_number, read_data, free_count, dirty,
                   input ready);
   modport sink   (input valid, found, block_number, read_data, free_count, dirty,
                   output ready);
endinterface

interface bba_csr_if;
   logic                      valid;
   logic                      ready;
   logic [bba_pkg::WIU_W-1:0] words_in_use;

   modport source (output valid, words_in_use, input ready);
   modport sink   (input valid, words_in_use, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bba_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module bba_ram #(
   parameter int WIDTH = bba_pkg::DATA_W,
   parameter int DEPTH = bba_pkg::MAP_WORDS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic                                   re,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Hold read data while no read is issued.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/bitmap_block_allocator_top.sv @@
// Top level of the bitmap first-fit block allocator.
//
//   channel    dir   role                 payload
//   req_chan   in    operation word       operation, word_index, word_data
//   rsp_chan   out   result word          found, block_number, read_data,
//                                         free_count, dirty
//   csr_chan   in    register write word  words_in_use
//
// Write map word, set free count, clear dirty and unknown codes pass through a
// pending state to the result register; read map word waits in ST_READ for one RAM read.
// Allocate scans up to N = min(words_in_use, MAP_WORDS) words, none when N is zero:
// the scan reads one bitmap word per cycle from the single RAM read port.
// Reset clears control, the free counter and the dirty mark and sets
// words_in_use to 1024; the bitmap RAM is not cleared and holds garbage
// until written. A stalled result register holds the finishing step in place.
`default_nettype none

module bitmap_block_allocator_top #(
   parameter int MAP_WORDS = bba_pkg::MAP_WORDS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   bba_req_if.sink    req_chan,
   bba_rsp_if.source  rsp_chan,
   bba_csr_if.sink    csr_chan
);

   localparam int AW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int LW  = ($clog2(MAP_WORDS + 1) > bba_pkg::WIU_W) ?
                        $clog2(MAP_WORDS + 1) : bba_pkg::WIU_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PEND = 4'b0010,
      ST_READ = 4'b0100,
      ST_SCAN = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // latched request word
   logic [bba_pkg::OP_W-1:0]   op_ff, op_in;
   logic [bba_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [bba_pkg::DATA_W-1:0] data_ff, data_in;

   // scan pointers
   logic [LW-1:0] limit_ff, limit_in;
   logic [LW-1:0] rd_addr_ff, rd_addr_in;
   logic [AW-1:0] chk_addr_ff, chk_addr_in;
   logic          chk_valid_ff, chk_valid_in;

   // architectural state
   logic [bba_pkg::WIU_W-1:0]  words_in_use_ff, words_in_use_in;
   logic [bba_pkg::DATA_W-1:0] free_blocks_ff, free_blocks_in;
   logic                       dirty_ff, dirty_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [bba_pkg::BLK_W-1:0]  rsp_block_ff, rsp_block_in;
   logic [bba_pkg::DATA_W-1:0] rsp_read_ff, rsp_read_in;
   logic [bba_pkg::DATA_W-1:0] rsp_count_ff, rsp_count_in;
   logic                       rsp_dirty_ff, rsp_dirty_in;

   // RAM port signals
   logic                       ram_we, ram_re;
   logic [AW-1:0]              ram_waddr, ram_raddr;
   logic [bba_pkg::DATA_W-1:0] ram_wdata, ram_rdata;

   logic                       out_free;
   logic                       load;
   logic                       ld_found;
   logic [bba_pkg::BLK_W-1:0]  ld_block;
   logic [bba_pkg::DATA_W-1:0] ld_read;
   logic                       req_in_map, idx_in_map;
   logic [LW-1:0]              limit_now;
   logic [4:0]                 clear_pos;

   bba_ram #(
      .WIDTH (bba_pkg::DATA_W),
      .DEPTH (MAP_WORDS)
   ) u_map_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign req_in_map = (32'(req_chan.word_index) < 32'(MAP_WORDS));
   assign idx_in_map = (32'(idx_ff) < 32'(MAP_WORDS));
   assign clear_pos  = bba_pkg::first_clear(ram_rdata);

   // Clamp the scan length to the map size.
   assign limit_now = (32'(words_in_use_ff) > 32'(MAP_WORDS)) ?
                      LW'(MAP_WORDS) : LW'(words_in_use_ff);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.found        = rsp_found_ff;
   assign rsp_chan.block_number = rsp_block_ff;
   assign rsp_chan.read_data    = rsp_read_ff;
   assign rsp_chan.free_count   = rsp_count_ff;
   assign rsp_chan.dirty        = rsp_dirty_ff;

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      idx_in          = idx_ff;
      data_in         = data_ff;
      limit_in        = limit_ff;
      rd_addr_in      = rd_addr_ff;
      chk_addr_in     = chk_addr_ff;
      chk_valid_in    = chk_valid_ff;
      words_in_use_in = words_in_use_ff;
      free_blocks_in  = free_blocks_ff;
      dirty_in        = dirty_ff;

      ram_we    = 1'b0;
      ram_waddr = AW'(idx_ff);
      ram_wdata = data_ff;
      ram_re    = 1'b0;
      ram_raddr = AW'(rd_addr_ff);

      load     = 1'b0;
      ld_found = 1'b0;
      ld_block = '0;
      ld_read  = '0;

      if (csr_chan.valid) begin
         words_in_use_in = csr_chan.words_in_use;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in   = req_chan.operation;
               idx_in  = req_chan.word_index;
               data_in = req_chan.word_data;
               priority if (req_chan.operation == bba_pkg::OP_ALLOCATE) begin
                  limit_in     = limit_now;
                  rd_addr_in   = '0;
                  chk_valid_in = 1'b0;
                  state_in     = ST_SCAN;
               end else if (req_chan.operation == bba_pkg::OP_READ_WORD) begin
                  // issue the read now, data arrives in ST_READ
                  ram_re    = req_in_map;
                  ram_raddr = AW'(req_chan.word_index);
                  state_in  = ST_READ;
               end else begin
                  state_in = ST_PEND;
               end
            end
         end

         ST_PEND: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
               priority if (op_ff == bba_pkg::OP_WRITE_WORD) begin
                  ram_we = idx_in_map;
               end else if (op_ff == bba_pkg::OP_SET_COUNT) begin
                  free_blocks_in = data_ff;
               end else if (op_ff == bba_pkg::OP_CLEAR_DIRTY) begin
                  dirty_in = 1'b0;
               end else begin
                  // unknown code: no state change
                  load = 1'b1;
               end
            end
         end

         ST_READ: begin
            if (out_free) begin
               load     = 1'b1;
               ld_read  = idx_in_map ? ram_rdata : '0;
               state_in = ST_IDLE;
            end
         end

         ST_SCAN: begin
            if (chk_valid_ff && (ram_rdata != bba_pkg::ALL_USED)) begin
               // free bit in the checked word: claim it, issue no further read
               if (out_free) begin
                  load      = 1'b1;
                  ld_found  = 1'b1;
                  ld_block  = (bba_pkg::BLK_W'(chk_addr_ff) << 5) |
                              bba_pkg::BLK_W'(clear_pos);
                  ram_we    = 1'b1;
                  ram_waddr = chk_addr_ff;
                  ram_wdata = ram_rdata | (32'd1 << clear_pos);
                  if (free_blocks_ff != '0) begin
                     free_blocks_in = free_blocks_ff - 32'd1;
                  end
                  dirty_in     = 1'b1;
                  chk_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else if (rd_addr_ff < limit_ff) begin
               // advance: fetch the next word while checking this one
               ram_re       = 1'b1;
               chk_valid_in = 1'b1;
               chk_addr_in  = AW'(rd_addr_ff);
               rd_addr_in   = rd_addr_ff + LW'(1);
            end else if (out_free) begin
               // every word in use is full
               load         = 1'b1;
               chk_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in = rsp_found_ff;
      rsp_block_in = rsp_block_ff;
      rsp_read_in  = rsp_read_ff;
      rsp_count_in = rsp_count_ff;
      rsp_dirty_in = rsp_dirty_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = ld_found;
         rsp_block_in = ld_block;
         rsp_read_in  = ld_read;
         rsp_count_in = free_blocks_in;
         rsp_dirty_in = dirty_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         chk_valid_ff    <= 1'b0;
         words_in_use_ff <= bba_pkg::WIU_RESET;
         free_blocks_ff  <= '0;
         dirty_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         chk_valid_ff    <= chk_valid_in;
         words_in_use_ff <= words_in_use_in;
         free_blocks_ff  <= free_blocks_in;
         dirty_ff        <= dirty_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      data_ff      <= data_in;
      limit_ff     <= limit_in;
      rd_addr_ff   <= rd_addr_in;
      chk_addr_ff  <= chk_addr_in;
      rsp_found_ff <= rsp_found_in;
      rsp_block_ff <= rsp_block_in;
      rsp_read_ff  <= rsp_read_in;
      rsp_count_ff <= rsp_count_in;
      rsp_dirty_ff <= rsp_dirty_in;
   end

`ifndef ASSERT_OFF
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && ram_re |-> rd_addr_ff < limit_ff)
      else $error("scan read beyond words in use");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !ram_re)
      else $error("map write and read in the same cycle");

   a_found_sets_dirty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> rsp_dirty_ff && (rsp_read_ff == '0))
      else $error("allocation result without dirty mark or with read data");

   a_miss_zero_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_block_ff == '0)
      else $error("block number set without a found block");
`endif

endmodule

`default_nettype wire

@@ sim/bitmap_block_allocator_checker.sv @@
// Result checker for the bitmap block allocator: predicts every result word and compares it.
`timescale 1ns / 100ps

module bitmap_block_allocator_checker (
   input  logic clock,
   input  logic reset,
   bba_req_if   req_mon,
   bba_rsp_if   rsp_mon,
   bba_csr_if   csr_mon,
   output int   mismatch_count,
   output int   pending_results
);

   typedef logic [bba_pkg::DATA_W-1:0] data_type;
   typedef logic [bba_pkg::BLK_W-1:0]  blk_type;

   typedef struct packed {
      logic     found;
      blk_type  block_number;
      data_type read_data;
      data_type free_count;
      logic     dirty;
   } alloc_result_type;

   data_type                  map_image [bba_pkg::MAP_WORDS_DEF];
   data_type                  free_counter;
   logic                      dirty_mark;
   logic [bba_pkg::WIU_W-1:0] scan_words;
   alloc_result_type          expected_results [$];
   int                        mismatches = 0;

   // Apply one operation word to the shadow state and return the result it yields.
   function automatic alloc_result_type apply_request(
         input logic [bba_pkg::OP_W-1:0]  op,
         input logic [bba_pkg::IDX_W-1:0] idx,
         input data_type                  data);
      alloc_result_type res;
      int               limit;
      int               pos;
      data_type         word;
      res = '0;
      case (op)
         bba_pkg::OP_WRITE_WORD: begin
            if (int'(idx) < bba_pkg::MAP_WORDS_DEF) map_image[idx] = data;
         end
         bba_pkg::OP_ALLOCATE: begin
            limit = (int'(scan_words) > bba_pkg::MAP_WORDS_DEF) ? bba_pkg::MAP_WORDS_DEF :
                                                                 int'(scan_words);
            for (int w = 0; w < limit && !res.found; w++) begin
               word = map_image[w];
               pos  = -1;
               for (int b = 0; b < bba_pkg::DATA_W && pos < 0; b++) begin
                  if (!word[b]) pos = b;
               end
               if (pos >= 0) begin
                  map_image[w][pos] = 1'b1;
                  if (free_counter != '0) free_counter = free_counter - data_type'(1);
                  dirty_mark         = 1'b1;
                  res.found          = 1'b1;
                  res.block_number   = blk_type'(w * bba_pkg::DATA_W + pos);
               end
            end
         end
         bba_pkg::OP_SET_COUNT:   free_counter = data;
         bba_pkg::OP_READ_WORD: begin
            if (int'(idx) < bba_pkg::MAP_WORDS_DEF) res.read_data = map_image[idx];
         end
         bba_pkg::OP_CLEAR_DIRTY: dirty_mark = 1'b0;
         default: ;
      endcase
      res.free_count = free_counter;
      res.dirty      = dirty_mark;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input data_type want,
                                  input data_type got);
      $display("%0t ns: result word mismatch on %s: expected %h, got %h",
               $time, what, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      alloc_result_type exp;
      if (reset) begin
         expected_results.delete();
         free_counter = '0;
         dirty_mark   = 1'b0;
         scan_words   = bba_pkg::WIU_RESET;
      end else begin
         // compare first: a result never belongs to the word accepted at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result word", '0, rsp_mon.read_data);
            end else begin
               exp = expected_results.pop_front();
               if (rsp_mon.found !== exp.found)
                  report_mismatch("found", data_type'(exp.found), data_type'(rsp_mon.found));
               if (rsp_mon.block_number !== exp.block_number)
                  report_mismatch("block_number", data_type'(exp.block_number),
                                  data_type'(rsp_mon.block_number));
               if (rsp_mon.read_data !== exp.read_data)
                  report_mismatch("read_data", exp.read_data, rsp_mon.read_data);
               if (rsp_mon.free_count !== exp.free_count)
                  report_mismatch("free_count", exp.free_count, rsp_mon.free_count);
               if (rsp_mon.dirty !== exp.dirty)
                  report_mismatch("dirty", data_type'(exp.dirty), data_type'(rsp_mon.dirty));
            end
         end
         if (csr_mon.valid && csr_mon.ready) scan_words = csr_mon.words_in_use;
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(apply_request(req_mon.operation, req_mon.word_index,
                                                     req_mon.word_data));
      end
      mismatch_count  <= mismatches;
      pending_results <= expected_results.size();
   end

endmodule

@@ sim/bitmap_block_allocator_top_test.sv @@
// Testbench top for the bitmap block allocator: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module bitmap_block_allocator_top_test;

   typedef logic [bba_pkg::OP_W-1:0]   code_type;
   typedef logic [bba_pkg::IDX_W-1:0]  idx_type;
   typedef logic [bba_pkg::DATA_W-1:0] data_type;
   typedef logic [bba_pkg::WIU_W-1:0]  count_type;

   // Codes outside the operation set; the block must answer them without side effects.
   localparam code_type OP_UNUSED_LO = 3'd5;
   localparam code_type OP_UNUSED_HI = 3'd7;

   // Long receiver hold-off, long enough to back the block up into its input.
   localparam int LONG_HOLD   = 300;
   // Cycles with no accepted word before giving up; the longest scan
   // plus the long receiver hold fits many times over.
   localparam int QUIET_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset;

   bba_req_if req_bus ();
   bba_rsp_if rsp_bus ();
   bba_csr_if csr_bus ();

   int  mismatch_count;
   int  pending_results;

   // Map words written since reset; allocate scans and reads touch only these.
   bit  map_loaded [bba_pkg::MAP_WORDS_DEF];
   int  map_prefix;
   int  burst_left    = 0;
   int  words_sent    = 0;
   int  allocs_sent   = 0;
   int  settings_used = 0;
   bit  hold_request  = 1'b0;

   bitmap_block_allocator_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   bitmap_block_allocator_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_mon         (csr_bus),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mostly full words so allocate has to scan; some with one hole, some random.
   function automatic data_type fill_word();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return bba_pkg::ALL_USED;
      if (pick < 9) return ~(32'h1 << $urandom_range(0, 31));
      return $urandom;
   endfunction

   // Drop valid on a falling clock edge.
   task automatic hold_sender();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   // Present one operation word and hold it until the block takes it.
   task automatic send_word(input code_type op, input idx_type idx, input data_type data);
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.word_index <= idx;
      req_bus.word_data  <= data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
      if (op == bba_pkg::OP_ALLOCATE) allocs_sent++;
   endtask

   // Send in bursts of random length; a third of the bursts follow back to back.
   task automatic offer_word(input code_type op, input idx_type idx, input data_type data);
      if (burst_left == 0) begin
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) hold_sender();
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      send_word(op, idx, data);
   endtask

   // Stop offering and wait until every predicted result word has come back.
   task automatic drain_results();
      hold_sender();
      while (pending_results != 0) @(negedge clock);
   endtask

   // Write words_in_use with the block idle.
   task automatic write_scan_words(input count_type value);
      drain_results();
      @(negedge clock);
      csr_bus.valid        <= 1'b1;
      csr_bus.words_in_use <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   // Write words_in_use, then load any word the scan may reach.
   task automatic set_scan_words(input count_type value);
      write_scan_words(value);
      map_prefix = (int'(value) > bba_pkg::MAP_WORDS_DEF) ? bba_pkg::MAP_WORDS_DEF :
                                                            int'(value);
      for (int w = 0; w < map_prefix; w++) begin
         if (!map_loaded[w]) begin
            offer_word(bba_pkg::OP_WRITE_WORD, idx_type'(w), fill_word());
            map_loaded[w] = 1'b1;
         end
      end
   endtask

   // Large setting with only a short prefix loaded: clear word 0 so every
   // allocate stops there, and take fewer blocks than the word holds.
   task automatic wide_scan(input count_type value, input int count);
      write_scan_words(value);
      offer_word(bba_pkg::OP_WRITE_WORD, '0, '0);
      map_loaded[0] = 1'b1;
      for (int i = 0; i < count; i++) begin
         if (i % 4 == 3) offer_word(bba_pkg::OP_READ_WORD, '0, '0);
         else            offer_word(bba_pkg::OP_ALLOCATE, '0, '0);
      end
   endtask

   // Random mix weighted toward allocate; reads go only to loaded words.
   task automatic run_random(input int count);
      int       pick;
      code_type op;
      idx_type  idx;
      data_type data;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         idx  = idx_type'($urandom);
         data = $urandom;
         if (pick < 20) begin
            op = bba_pkg::OP_WRITE_WORD;
            if (map_prefix > 0 && $urandom_range(0, 1) == 1)
               idx = idx_type'($urandom_range(0, map_prefix - 1));
            data = fill_word();
            map_loaded[idx] = 1'b1;
         end else if (pick < 55) begin
            op = bba_pkg::OP_ALLOCATE;
         end else if (pick < 63) begin
            op = bba_pkg::OP_SET_COUNT;
            case ($urandom_range(0, 4))
               0:       data = '0;
               1:       data = 32'd1;
               2:       data = bba_pkg::ALL_USED;
               3:       data = $urandom_range(0, 40);
               default: ;
            endcase
         end else if (pick < 83) begin
            op = bba_pkg::OP_READ_WORD;
            if (!map_loaded[idx])
               idx = (map_prefix > 0) ? idx_type'($urandom_range(0, map_prefix - 1)) : '0;
         end else if (pick < 93) begin
            op = bba_pkg::OP_CLEAR_DIRTY;
         end else begin
            op = code_type'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         end
         offer_word(op, idx, data);
      end
   endtask

   // Receiver: stall on a rotating 8-bit pattern, changed every stretch;
   // on request, hold ready low in one unbroken stretch.
   initial begin : result_sink
      logic [7:0] pattern;
      int         stretch;
      rsp_bus.ready <= 1'b0;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            repeat (LONG_HOLD) begin
               @(negedge clock);
               rsp_bus.ready <= 1'b0;
            end
         end else begin
            stretch = $urandom_range(16, 96);
            case ($urandom_range(0, 2))
               0:       pattern = 8'hFF;
               1:       pattern = 8'($urandom) | 8'h01;
               default: pattern = (8'($urandom) & 8'($urandom)) | 8'h80;
            endcase
            for (int k = 0; k < stretch; k++) begin
               @(negedge clock);
               rsp_bus.ready <= pattern[k % 8];
            end
         end
      end
   end

   // Watchdog: end the run when no word moves on any channel for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t ns: no word accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("bitmap_block_allocator_top verification failed");
      $finish;
   end

   initial begin : stimulus
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.operation    = '0;
      req_bus.word_index   = '0;
      req_bus.word_data    = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.words_in_use = '0;
      map_prefix           = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Nothing is loaded yet: no allocate may run until words_in_use is small.
      // Zero words in use: allocate scans nothing and reports not found.
      set_scan_words(11'd0);
      offer_word(bba_pkg::OP_ALLOCATE, '0, '0);
      offer_word(bba_pkg::OP_WRITE_WORD, 10'd0, bba_pkg::ALL_USED);
      map_loaded[0] = 1'b1;
      offer_word(bba_pkg::OP_WRITE_WORD, 10'd1023, '0);
      map_loaded[1023] = 1'b1;
      offer_word(bba_pkg::OP_READ_WORD, 10'd0, '0);
      offer_word(bba_pkg::OP_READ_WORD, 10'd1023, bba_pkg::ALL_USED);
      offer_word(bba_pkg::OP_SET_COUNT, 10'd1023, bba_pkg::ALL_USED);
      offer_word(OP_UNUSED_LO, 10'd1023, bba_pkg::ALL_USED);
      offer_word(OP_UNUSED_LO + 3'd1, '0, '0);
      offer_word(OP_UNUSED_HI, 10'd511, 32'h5555_AAAA);
      offer_word(bba_pkg::OP_ALLOCATE, 10'd1023, bba_pkg::ALL_USED);
      offer_word(bba_pkg::OP_CLEAR_DIRTY, '0, '0);

      // One word in use: full word, last-bit hole, counter saturating at zero.
      set_scan_words(11'd1);
      offer_word(bba_pkg::OP_ALLOCATE, '0, '0);
      offer_word(bba_pkg::OP_WRITE_WORD, 10'd0, 32'h7FFF_FFFF);
      offer_word(bba_pkg::OP_ALLOCATE, '0, '0);
      offer_word(bba_pkg::OP_ALLOCATE, '0, '0);
      offer_word(bba_pkg::OP_SET_COUNT, '0, '0);
      offer_word(bba_pkg::OP_WRITE_WORD, 10'd0, 32'hFFFF_FFFE);
      offer_word(bba_pkg::OP_ALLOCATE, '0, '0);
      offer_word(bba_pkg::OP_READ_WORD, 10'd0, '0);
      offer_word(bba_pkg::OP_CLEAR_DIRTY, '0, '0);
      offer_word(bba_pkg::OP_WRITE_WORD, 10'd0, '0);
      offer_word(bba_pkg::OP_ALLOCATE, '0, '0);
      offer_word(bba_pkg::OP_ALLOCATE, '0, '0);
      run_random(40);

      // Small map: back up the block with a long receiver hold, then pause
      // the sender until every result is home.
      set_scan_words(11'($urandom_range(20, 48)));
      run_random(30);
      hold_request = 1'b1;
      run_random(60);
      drain_results();
      run_random(30);

      // Whole map, then a setting above the map size; word 0 holds the free blocks.
      wide_scan(11'd1024, 30);
      wide_scan(11'd2047, 30);

      // Back to short scans, where words fill up and holes get reloaded.
      set_scan_words(11'($urandom_range(2, 16)));
      run_random(150);
      set_scan_words(11'($urandom_range(1, 64)));
      run_random(150);

      drain_results();
      repeat (8) @(negedge clock);
      $display("Covered %0d operation words (%0d allocates) over %0d words_in_use settings,",
               words_sent, allocs_sent, settings_used);
      $display("including zero, one, small, full-map and oversize settings and a long stall.");
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("bitmap_block_allocator_top verification clean");
      end else begin
         $display("bitmap_block_allocator_top verification failed");
      end
      $finish;
   end

endmodule
